// File: src/ppr_pkg.sv
package ppr_pkg;

   localparam int ChanBits    = 5;
   localparam int MapRegs     = 4;
   localparam int MapEntries  = 8;
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = 64;
   localparam int RowBits     = 6;

   localparam logic [CsrIdxBits-1:0] CSR_START_ROW  = 3'd0;
   localparam logic [CsrIdxBits-1:0] CSR_CHAN_MAP_A = 3'd1;
   localparam logic [CsrIdxBits-1:0] CSR_CHAN_MAP_B = 3'd2;
   localparam logic [CsrIdxBits-1:0] CSR_CHAN_MAP_C = 3'd3;
   localparam logic [CsrIdxBits-1:0] CSR_CHAN_MAP_D = 3'd4;

   localparam logic [39:0] FIELD_DEFAULTS = 40'hFF_00_FF_00_00;
   localparam logic [RowBits-1:0] ROW_LAST = 6'd63;

   typedef enum logic [2:0] {
      PH_LEAD = 3'd0,
      PH_NOTE = 3'd1,
      PH_INS  = 3'd2,
      PH_VOL  = 3'd3,
      PH_CMD  = 3'd4,
      PH_INFO = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] pattern_byte;
      logic       start_of_pattern;
   } req_type;

   typedef struct packed {
      logic               end_of_row;
      logic [RowBits-1:0] row_number;
      logic [6:0]         out_channel;
      logic [7:0]         note_value;
      logic [7:0]         instrument;
      logic [7:0]         volume;
      logic [7:0]         command;
      logic [7:0]         info;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type data;
   } step_type;

   // Phase that follows p for an event with the given presence flags.
   function automatic phase_type next_phase(input phase_type p, input logic [2:0] flags);
      phase_type q;
      begin
         q = PH_LEAD;
         case (p)
            PH_LEAD: q = flags[0] ? PH_NOTE : flags[1] ? PH_VOL : flags[2] ? PH_CMD : PH_LEAD;
            PH_NOTE: q = flags[0] ? PH_INS : flags[1] ? PH_VOL : flags[2] ? PH_CMD : PH_LEAD;
            PH_INS:  q = flags[1] ? PH_VOL : flags[2] ? PH_CMD : PH_LEAD;
            PH_VOL:  q = flags[2] ? PH_CMD : PH_LEAD;
            PH_CMD:  q = flags[2] ? PH_INFO : PH_LEAD;
            default: q = PH_LEAD;
         endcase
         return q;
      end
   endfunction

endpackage

// File: src/ppr_csr.sv
module ppr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ppr_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [ppr_pkg::CsrDataBits-1:0] csr_wdata,
   input  logic [ppr_pkg::ChanBits-1:0]   src_chan,
   output logic [7:0]                     map_entry,
   output logic [ppr_pkg::RowBits-1:0]    start_row
);
   import ppr_pkg::*;

   logic [CsrDataBits-1:0] chan_map_ff [MapRegs];
   logic [RowBits-1:0]     start_row_ff;
   logic [CsrDataBits-1:0] map_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff <= '0;
         for (int i = 0; i < MapRegs; i++) begin
            chan_map_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_ROW:  start_row_ff   <= csr_wdata[RowBits-1:0];
            CSR_CHAN_MAP_A: chan_map_ff[0] <= csr_wdata;
            CSR_CHAN_MAP_B: chan_map_ff[1] <= csr_wdata;
            CSR_CHAN_MAP_C: chan_map_ff[2] <= csr_wdata;
            CSR_CHAN_MAP_D: chan_map_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Upper two channel bits pick the word, lower three pick the byte.
   assign map_word  = chan_map_ff[src_chan[4:3]];
   assign map_entry = map_word[{src_chan[2:0], 3'b000} +: 8];
   assign start_row = start_row_ff;

endmodule

// File: src/ppr_parser.sv
module ppr_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  ppr_pkg::req_type            item,
   input  logic [7:0]                  map_entry,
   input  logic [ppr_pkg::RowBits-1:0] start_row,
   output ppr_pkg::step_type           result
);
   import ppr_pkg::*;

   phase_type          phase_ff, phase_in, cur_phase;
   logic [2:0]         flags_ff, flags_in, cur_flags;
   logic [7:0]         chan_ff, chan_in;
   logic [39:0]        fields_ff, fields_in, cur_fields;
   logic [RowBits-1:0] row_ff, row_in, cur_row;
   logic [7:0]         b;

   assign b = item.pattern_byte;

   // Start of pattern clears the parse state before the byte is used.
   always_comb begin
      cur_phase  = item.start_of_pattern ? PH_LEAD : phase_ff;
      cur_flags  = item.start_of_pattern ? 3'd0 : flags_ff;
      cur_fields = item.start_of_pattern ? FIELD_DEFAULTS : fields_ff;
      cur_row    = item.start_of_pattern ? '0 : row_ff;
   end

   // Next state.
   always_comb begin
      phase_in  = cur_phase;
      flags_in  = cur_flags;
      chan_in   = chan_ff;
      fields_in = cur_fields;
      row_in    = cur_row;
      case (cur_phase)
         PH_NOTE: fields_in[39:32] = b;
         PH_INS:  fields_in[31:24] = b;
         PH_VOL:  fields_in[23:16] = b;
         PH_CMD:  fields_in[15:8]  = b;
         PH_INFO: fields_in[7:0]   = b;
         default: begin
            if (b == 8'd0) begin
               if (cur_row != ROW_LAST) begin
                  row_in = cur_row + 1'b1;
               end
            end else begin
               flags_in  = b[7:5];
               chan_in   = map_entry;
               fields_in = FIELD_DEFAULTS;
            end
         end
      endcase
      if (cur_phase == PH_LEAD && b == 8'd0) begin
         phase_in = PH_LEAD;
      end else begin
         phase_in = next_phase(cur_phase, flags_in);
      end
   end

   // Outputs: an unmuted event result when the last byte of an event lands, or a
   // row terminator, in both cases only from the start row on.
   always_comb begin
      result.emit             = 1'b0;
      result.data.end_of_row  = 1'b0;
      result.data.row_number  = cur_row;
      result.data.out_channel = chan_in[6:0];
      {result.data.note_value, result.data.instrument, result.data.volume,
       result.data.command, result.data.info} = fields_in;
      if (cur_phase == PH_LEAD && b == 8'd0) begin
         result.emit             = cur_row >= start_row;
         result.data.end_of_row  = 1'b1;
         result.data.out_channel = '0;
         {result.data.note_value, result.data.instrument, result.data.volume,
          result.data.command, result.data.info} = FIELD_DEFAULTS;
      end else if (phase_in == PH_LEAD) begin
         result.emit = !chan_in[7] && (cur_row >= start_row);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         flags_ff  <= '0;
         chan_ff   <= '0;
         fields_ff <= FIELD_DEFAULTS;
         row_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         flags_ff  <= flags_in;
         chan_ff   <= chan_in;
         fields_ff <= fields_in;
         row_ff    <= row_in;
      end
   end

endmodule

// File: src/packed_pattern_row_decoder.sv
// Packed pattern row decoder: one pattern byte in per cycle, at most one word out.
// An accepted byte passes from the input register through the parse-to-result path
// into the result register.
// Throughput: one byte per cycle while the result register is free or being emptied.
// Reset (synchronous, active high) clears the parser, the row counter, the register
// settings and both valid flags; the block is ready as soon as reset is released.
module packed_pattern_row_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ppr_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ppr_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [ppr_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [ppr_pkg::CsrDataBits-1:0] csr_wdata
);
   import ppr_pkg::*;

   // Input register holding one accepted pattern word.
   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;

   // Result register facing the output channel.
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff;

   logic               advance;
   logic               step;
   logic               req_fire;
   logic [7:0]         map_entry;
   logic [RowBits-1:0] start_row;
   step_type           result;

   // The input register can hand its word on whenever the result register
   // is empty or being emptied in this cycle.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   ppr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .src_chan  (in_data_ff.pattern_byte[ChanBits-1:0]),
      .map_entry (map_entry),
      .start_row (start_row)
   );

   ppr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_data_ff),
      .map_entry (map_entry),
      .start_row (start_row),
      .result    (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // A step with no result still drains a word that was just taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step) begin
         rsp_valid_in = result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (step && result.emit) begin
         rsp_data_ff <= result.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: tb/tb_packed_pattern_row_decoder.sv
module tb_packed_pattern_row_decoder;
   import ppr_pkg::*;

   // Cycles the receiver refuses words in the long hold-off. This is far longer
   // than the two-stage pipeline, so the block has to stall its input.
   localparam int HoldCycles  = 60;
   // Quiet cycles allowed after the last expected word before registers change.
   // A byte that makes no word may still sit in the two pipeline stages.
   localparam int DrainCycles = 6;
   // Cycles with no handshake and no register write before the run is abandoned.
   localparam int StallLimit  = 2000;
   // The first register index that the block has no register for.
   localparam logic [CsrIdxBits-1:0] CsrSpare = CSR_CHAN_MAP_D + 1'b1;

   // Tracks the parser state of the block and keeps the words it must produce,
   // oldest first. The channel map and start row are mirrored here as written.
   class row_event_book;
      logic [RowBits-1:0]     first_row;
      logic [CsrDataBits-1:0] chan_maps [MapRegs];
      phase_type              parse_at;
      logic [2:0]             present;
      logic [7:0]             entry;
      logic [39:0]            fields;
      logic [RowBits-1:0]     row;
      rsp_type                awaited [$];
      int bytes_seen, words_predicted, row_ends, words_checked, errors;

      function new();
         first_row = '0;
         foreach (chan_maps[k]) chan_maps[k] = '0;
         parse_at = PH_LEAD;
         present = '0;
         entry = '0;
         fields = FIELD_DEFAULTS;
         row = '0;
         bytes_seen = 0;
         words_predicted = 0;
         row_ends = 0;
         words_checked = 0;
         errors = 0;
      endfunction

      function void set_register(logic [CsrIdxBits-1:0] idx, logic [CsrDataBits-1:0] value);
         case (idx)
            CSR_START_ROW:  first_row = value[RowBits-1:0];
            CSR_CHAN_MAP_A: chan_maps[0] = value;
            CSR_CHAN_MAP_B: chan_maps[1] = value;
            CSR_CHAN_MAP_C: chan_maps[2] = value;
            CSR_CHAN_MAP_D: chan_maps[3] = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // The next field that the current event still carries, or the lead byte
      // once the event is complete.
      function phase_type advance(phase_type cur);
         int q;
         for (q = int'(cur) + 1; q <= int'(PH_INFO); q++) begin
            if (q <= int'(PH_INS) && present[0]) return phase_type'(q);
            if (q == int'(PH_VOL) && present[1]) return phase_type'(q);
            if (q >= int'(PH_CMD) && present[2]) return phase_type'(q);
         end
         return PH_LEAD;
      endfunction

      function void push_word(logic eor, logic [6:0] chan, logic [39:0] f);
         rsp_type w;
         w.end_of_row  = eor;
         w.row_number  = row;
         w.out_channel = chan;
         {w.note_value, w.instrument, w.volume, w.command, w.info} = f;
         awaited.push_back(w);
         words_predicted++;
         if (eor) row_ends++;
      endfunction

      // Runs one accepted pattern byte through the parser.
      function void take_byte(req_type item);
         logic [7:0] b;
         int shift;
         b = item.pattern_byte;
         bytes_seen++;
         if (item.start_of_pattern) begin
            parse_at = PH_LEAD;
            present = '0;
            fields = FIELD_DEFAULTS;
            row = '0;
         end
         if (parse_at == PH_LEAD) begin
            if (b == 8'h00) begin
               if (row >= first_row) push_word(1'b1, 7'd0, FIELD_DEFAULTS);
               if (row != ROW_LAST) row++;
               return;
            end
            present = b[7:5];
            entry = chan_maps[b[4:3]][8 * b[2:0] +: 8];
            fields = FIELD_DEFAULTS;
            parse_at = advance(PH_LEAD);
         end else begin
            // Note sits in the top byte, info in the bottom one.
            shift = (int'(PH_INFO) - int'(parse_at)) * 8;
            fields[shift +: 8] = b;
            parse_at = advance(parse_at);
         end
         if (parse_at == PH_LEAD && !entry[7] && row >= first_row)
            push_word(1'b0, entry[6:0], fields);
      endfunction

      function void compare(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("result word %h arrived with nothing predicted", got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         words_checked++;
         compare("end_of_row", 8'(want.end_of_row), 8'(got.end_of_row));
         compare("row_number", 8'(want.row_number), 8'(got.row_number));
         compare("out_channel", 8'(want.out_channel), 8'(got.out_channel));
         compare("note_value", want.note_value, got.note_value);
         compare("instrument", want.instrument, got.instrument);
         compare("volume", want.volume, got.volume);
         compare("command", want.command, got.command);
         compare("info", want.info, got.info);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CsrIdxBits-1:0]  csr_index = '0;
   logic [CsrDataBits-1:0] csr_wdata = '0;

   row_event_book book;
   // Set while neither side idles; set the hold request to make the receiver
   // refuse words for a long stretch.
   bit steady = 1'b0;
   bit hold_request = 1'b0;
   // The next byte offered opens a new pattern.
   bit fresh_pattern = 1'b0;
   int bytes_offered = 0;

   // A short opening script of {start_of_pattern, pattern_byte} pairs. It walks
   // through a row end, note and instrument with both extreme values, an event
   // with every field at its top value, an event with no fields, muted events
   // with and without fields, and an event cut off by the start of a new pattern.
   logic [8:0] opening [24] = '{
      9'h100,
      9'h020, 9'h000, 9'h0FF,
      9'h042, 9'h0FF,
      9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
      9'h004,
      9'h061, 9'h010, 9'h020, 9'h030,
      9'h000,
      9'h0A0, 9'h100,
      9'h003,
      9'h082, 9'h001, 9'h002
   };

   packed_pattern_row_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Both handshakes are sampled at the clock edge, before any of this edge's
   // updates land. The accepted byte is noted first so that a word could
   // never outrun its own prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) book.take_byte(req_data);
         if (rsp_valid && rsp_ready) book.check_word(rsp_data);
      end
   end

   // The receiver is ready at random, always ready in the steady stretch, and
   // on request it refuses words for a long stretch of its own counting.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= steady || ($urandom_range(99) >= 22);
      end
   end

   // Ends the run when neither channel nor the register port has moved for
   // far longer than any correct run would need.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [7:0] data_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [CsrDataBits-1:0] random_map();
      return {$urandom, $urandom};
   endfunction

   // Offers one byte and returns at the edge that accepts it. Valid stays high
   // afterwards, so back-to-back bytes need no gap.
   task automatic send_byte(input logic [7:0] value, input logic sop);
      req_type item;
      if (!steady) begin
         while ($urandom_range(99) < 22) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      item.pattern_byte = value;
      item.start_of_pattern = sop | fresh_pattern;
      fresh_pattern = 1'b0;
      req_data <= item;
      req_valid <= 1'b1;
      bytes_offered++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // One event with random flags, channel and data. A broken event is cut
   // short, so that the next byte is parsed as one of its fields.
   task automatic send_event(input bit broken);
      logic [2:0] flags;
      logic [4:0] src;
      int count;
      int k;
      flags = 3'($urandom_range(7));
      src = 5'($urandom_range(31));
      // A zero lead byte would end the row instead.
      if (flags == 3'd0 && src == 5'd0) src = 5'($urandom_range(31, 1));
      count = (flags[0] ? 2 : 0) + (flags[1] ? 1 : 0) + (flags[2] ? 2 : 0);
      if (broken && count > 0) count = $urandom_range(count - 1);
      send_byte({flags, src}, 1'b0);
      for (k = 0; k < count; k++) send_byte(data_byte(), 1'b0);
   endtask

   task automatic send_pattern(input int rows_lo, input int rows_hi, input int max_events);
      int rows;
      int r;
      rows = $urandom_range(rows_hi, rows_lo);
      fresh_pattern = 1'b1;
      for (r = 0; r < rows; r++) begin
         repeat ($urandom_range(max_events)) send_event($urandom_range(99) < 3);
         send_byte(8'h00, 1'b0);
      end
   endtask

   // Lowers valid after the last byte, waits for every predicted word and
   // then lets the pipeline empty of bytes that make no word.
   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Writes every register back to back, then one index with no register
   // behind it, which the block must ignore.
   task automatic load_settings(input logic [RowBits-1:0] row0,
                                input logic [CsrDataBits-1:0] a, b, c, d);
      logic [CsrDataBits-1:0] values [6];
      logic [CsrIdxBits-1:0]  slots [6];
      int k;
      slots = '{CSR_START_ROW, CSR_CHAN_MAP_A, CSR_CHAN_MAP_B, CSR_CHAN_MAP_C,
                CSR_CHAN_MAP_D, CsrSpare};
      values = '{CsrDataBits'(row0), a, b, c, d, random_map()};
      for (k = 0; k < 6; k++) begin
         csr_we <= 1'b1;
         csr_index <= slots[k];
         csr_wdata <= values[k];
         book.set_register(slots[k], values[k]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed patterns with random content, with short bursts of
   // raw noise that may restart the pattern at any point.
   task automatic run_phase(input int items, input int rows_lo, input int rows_hi,
                            input int max_events, input int min_words);
      int start_bytes;
      int start_words;
      start_bytes = bytes_offered;
      start_words = book.words_predicted;
      while (bytes_offered - start_bytes < items
             || book.words_predicted - start_words < min_words) begin
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(6, 1)) send_byte(data_byte(), $urandom_range(7) == 0);
         else
            send_pattern(rows_lo, rows_hi, max_events);
      end
      settle();
   endtask

   initial begin : stimulus
      book = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Channel 0 maps to 5, channel 1 and 3 are muted, channel 2 maps to the
      // top channel and channel 31 maps to channel 0.
      load_settings(6'd0, 64'h1234_5678_FF7F_8005, random_map(), random_map(),
                    64'h00A5_5A3C_C381_7E01);
      foreach (opening[k]) send_byte(opening[k][7:0], opening[k][8]);
      settle();

      load_settings(6'd0, random_map(), random_map(), random_map(), random_map());
      run_phase(240, 1, 12, 4, 0);

      // A long stretch with no idling on either side and a mid-range seek.
      steady = 1'b1;
      load_settings(6'($urandom_range(62, 1)), random_map(), random_map(), random_map(),
                    random_map());
      run_phase(180, 1, 40, 3, 0);
      steady = 1'b0;

      // Every channel maps to 0 unmuted; the receiver holds off for a long
      // stretch at the start while bytes keep coming.
      load_settings(6'd0, '0, '0, '0, '0);
      hold_request = 1'b1;
      run_phase(220, 1, 12, 4, 0);

      // Seek to the last row with long, sparse patterns, so that words only
      // come once the row count has run into saturation.
      load_settings(ROW_LAST, random_map(), random_map(), random_map(), random_map());
      run_phase(150, 64, 90, 1, 10);

      // Every channel is muted, so only row ends come out.
      load_settings(6'd0, '1, '1, '1, '1);
      run_phase(200, 1, 12, 4, 0);

      $display("Checked %0d result words, %0d of them row ends, from %0d pattern bytes.",
               book.words_checked, book.row_ends, book.bytes_seen);
      $display("Settings spanned seeks to rows 0, 63 and mid-range, %s",
               "and empty, full and random maps.");
      if (book.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
src/ppr_pkg.sv
src/ppr_csr.sv
src/ppr_parser.sv
src/packed_pattern_row_decoder.sv
tb/tb_packed_pattern_row_decoder.sv
